>>> hdl/kqsb_pkg.sv
// shared constants and codes for the k-queue shared slot buffer
// no dependencies; imported by every module of the block
`default_nettype none

package kqsb_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam int unsigned QUEUES_DEF = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned QID_W      = 2;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_e;

endpackage

`default_nettype wire

>>> hdl/k_queues_shared_buffer.sv
// k first-in first-out queues sharing one slot store, linked lists plus a free list
// steps: overflow, underflow and enqueue to an empty queue finish in the look-up state;
// enqueue to a non-empty queue finishes in the link state, a good dequeue in the dequeue state
// flow: one item at a time, taken only when idle, with the pace set by the queue table read and the
// single-port link memory (read of the head link, then one or two link writes)
// reset: all queues empty, free list in slot order via a fill count, ready at once
`default_nettype none

module k_queues_shared_buffer import kqsb_pkg::*; #(
  parameter int unsigned SLOTS  = SLOTS_DEF,
  parameter int unsigned QUEUES = QUEUES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     cmd_i,
  input  wire logic [QID_W-1:0]         queue_id_i,
  input  wire logic signed [WORD_W-1:0] data_in_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [WORD_W-1:0]      data_out_o
);

  localparam int unsigned SW  = $clog2(SLOTS);
  localparam int unsigned PW  = $clog2(SLOTS + 1);
  localparam int unsigned QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned QXW = QW + QID_W;
  // null pointer: one past the last slot
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_LINK,
    S_DEQ
  } state_e;

  state_e            state_q, state_d;
  logic              cmd_q;
  logic [QW-1:0]     qaddr_q;
  logic              qok_q;
  logic [WORD_W-1:0] word_q;
  logic [PW-1:0]     slot_q;
  logic [PW-1:0]     tail_q;
  logic [PW-1:0]     free_head_q;
  logic [PW-1:0]     fresh_q;       // slots at and above this were never handed out
  logic              out_valid_q;
  status_e           status_q;
  logic [WORD_W-1:0] data_out_q;

  // queue number check and table address
  logic [QXW-1:0] q_ext;
  logic           q_ok_in;
  logic           take;
  logic           out_free;

  assign q_ext    = QXW'(queue_id_i);
  assign q_ok_in  = q_ext < QXW'(QUEUES);
  assign take     = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // memory side
  logic          qt_rd_en, qt_wr_en;
  logic [PW-1:0] qt_wr_head, qt_wr_tail;
  logic [PW-1:0] qt_head, qt_tail;
  logic [SW-1:0] ss_addr;
  logic          link_re, link_we, data_re, data_we;
  logic [PW-1:0] link_wdata, link_rdata;
  logic [WORD_W-1:0] data_rdata;

  // sequencing strobes
  logic              finish;
  status_e           res_status;
  logic [WORD_W-1:0] res_data;
  logic              alloc;
  logic              free_push;
  logic              capture;
  logic [PW-1:0]     cap_slot;
  logic [PW-1:0]     next_free;
  logic              q_empty;

  // a never-used slot at the free head links to the next slot in order
  assign next_free = (free_head_q == fresh_q) ? free_head_q + PW'(1) : link_rdata;
  assign q_empty   = (qt_head == NIL) || (qt_tail == NIL);

  always_comb begin
    state_d    = state_q;
    qt_rd_en   = 1'b0;
    qt_wr_en   = 1'b0;
    qt_wr_head = NIL;
    qt_wr_tail = NIL;
    ss_addr    = free_head_q[SW-1:0];
    link_re    = 1'b0;
    link_we    = 1'b0;
    link_wdata = NIL;
    data_re    = 1'b0;
    data_we    = 1'b0;
    finish     = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    alloc      = 1'b0;
    free_push  = 1'b0;
    capture    = 1'b0;
    cap_slot   = free_head_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          // look up the queue and the link of the free head together
          qt_rd_en = q_ok_in;
          link_re  = (free_head_q != NIL);
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (cmd_q == CMD_ENQ) begin
          if (!qok_q || free_head_q == NIL) begin
            if (out_free) begin
              finish     = 1'b1;
              res_status = ST_OVER;
              state_d    = S_IDLE;
            end
          end else if (!q_empty || out_free) begin
            // take the free head, store the word, terminate its link
            ss_addr    = free_head_q[SW-1:0];
            data_we    = 1'b1;
            link_we    = 1'b1;
            link_wdata = NIL;
            alloc      = 1'b1;
            qt_wr_en   = 1'b1;
            qt_wr_tail = free_head_q;
            if (q_empty) begin
              qt_wr_head = free_head_q;
              finish     = 1'b1;
              state_d    = S_IDLE;
            end else begin
              qt_wr_head = qt_head;
              capture    = 1'b1;
              cap_slot   = free_head_q;
              state_d    = S_LINK;
            end
          end
        end else begin
          if (!qok_q || qt_head == NIL) begin
            if (out_free) begin
              finish     = 1'b1;
              res_status = ST_UNDER;
              res_data   = '1;
              state_d    = S_IDLE;
            end
          end else begin
            // fetch word and link of the head slot
            ss_addr  = qt_head[SW-1:0];
            link_re  = 1'b1;
            data_re  = 1'b1;
            capture  = 1'b1;
            cap_slot = qt_head;
            state_d  = S_DEQ;
          end
        end
      end
      S_LINK: begin
        if (out_free) begin
          // chain the new slot after the old tail
          ss_addr    = tail_q[SW-1:0];
          link_we    = 1'b1;
          link_wdata = slot_q;
          finish     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DEQ: begin
        if (out_free) begin
          qt_wr_en = 1'b1;
          if (link_rdata >= NIL) begin
            qt_wr_head = NIL;
            qt_wr_tail = NIL;
          end else begin
            qt_wr_head = link_rdata;
            qt_wr_tail = tail_q;
          end
          // push the freed slot onto the free head
          ss_addr    = slot_q[SW-1:0];
          link_we    = 1'b1;
          link_wdata = free_head_q;
          free_push  = 1'b1;
          finish     = 1'b1;
          res_data   = data_rdata;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      if (alloc) begin
        free_head_q <= next_free;
        if (free_head_q == fresh_q) begin
          fresh_q <= fresh_q + PW'(1);
        end
      end else if (free_push) begin
        free_head_q <= slot_q;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q   <= cmd_i;
      qaddr_q <= q_ext[QW-1:0];
      qok_q   <= q_ok_in;
      word_q  <= data_in_i;
    end
    if (capture) begin
      slot_q <= cap_slot;
      tail_q <= qt_tail;
    end
    if (finish) begin
      data_out_q <= res_data;
    end
  end

  kqsb_queue_table #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_queue_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (qt_rd_en),
    .rd_addr_i (q_ext[QW-1:0]),
    .wr_en_i   (qt_wr_en),
    .wr_addr_i (qaddr_q),
    .wr_head_i (qt_wr_head),
    .wr_tail_i (qt_wr_tail),
    .rd_head_o (qt_head),
    .rd_tail_o (qt_tail)
  );

  kqsb_slot_store #(
    .SLOTS (SLOTS)
  ) u_slot_store (
    .clk_i        (clk_i),
    .addr_i       (ss_addr),
    .link_re_i    (link_re),
    .link_we_i    (link_we),
    .link_wdata_i (link_wdata),
    .link_rdata_o (link_rdata),
    .data_re_i    (data_re),
    .data_we_i    (data_we),
    .data_wdata_i (word_q),
    .data_rdata_o (data_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_out_q;

endmodule

`default_nettype wire

>>> hdl/kqsb_slot_store.sv
// slot word memory and slot link memory, one shared address, registered reads
// depends on kqsb_pkg
`default_nettype none

module kqsb_slot_store import kqsb_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned SW = $clog2(SLOTS),
  localparam int unsigned PW = $clog2(SLOTS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic [SW-1:0]     addr_i,
  input  wire logic              link_re_i,
  input  wire logic              link_we_i,
  input  wire logic [PW-1:0]     link_wdata_i,
  output logic      [PW-1:0]     link_rdata_o,
  input  wire logic              data_re_i,
  input  wire logic              data_we_i,
  input  wire logic [WORD_W-1:0] data_wdata_i,
  output logic      [WORD_W-1:0] data_rdata_o
);

  logic [PW-1:0]     link_mem [SLOTS];
  logic [WORD_W-1:0] data_mem [SLOTS];
  logic [PW-1:0]     link_rd_q;
  logic [WORD_W-1:0] data_rd_q;

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[addr_i] <= link_wdata_i;
    end
    if (link_re_i) begin
      link_rd_q <= link_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we_i) begin
      data_mem[addr_i] <= data_wdata_i;
    end
    if (data_re_i) begin
      data_rd_q <= data_mem[addr_i];
    end
  end

  assign link_rdata_o = link_rd_q;
  assign data_rdata_o = data_rd_q;

endmodule

`default_nettype wire

>>> hdl/kqsb_queue_table.sv
// per-queue head and tail pointer memory with valid bits for reset to empty
// depends on kqsb_pkg
`default_nettype none

module kqsb_queue_table import kqsb_pkg::*; #(
  parameter int unsigned SLOTS  = SLOTS_DEF,
  parameter int unsigned QUEUES = QUEUES_DEF,
  localparam int unsigned PW = $clog2(SLOTS + 1),
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [QW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [QW-1:0] wr_addr_i,
  input  wire logic [PW-1:0] wr_head_i,
  input  wire logic [PW-1:0] wr_tail_i,
  output logic      [PW-1:0] rd_head_o,
  output logic      [PW-1:0] rd_tail_o
);

  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  logic [PW-1:0]     head_mem [QUEUES];
  logic [PW-1:0]     tail_mem [QUEUES];
  logic [PW-1:0]     head_rd_q;
  logic [PW-1:0]     tail_rd_q;
  logic [QUEUES-1:0] vld_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      head_mem[wr_addr_i] <= wr_head_i;
      tail_mem[wr_addr_i] <= wr_tail_i;
    end
    if (rd_en_i) begin
      head_rd_q <= head_mem[rd_addr_i];
      tail_rd_q <= tail_mem[rd_addr_i];
    end
  end

  // an entry never written reads as an empty queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_head_o = rd_vld_q ? head_rd_q : NIL;
  assign rd_tail_o = rd_vld_q ? tail_rd_q : NIL;

endmodule

`default_nettype wire

>>> hdl/kqsb_checker.sv
// port-level checks for the k-queue shared slot buffer, bound to the top level
// depends on kqsb_pkg and k_queues_shared_buffer
`default_nettype none

module kqsb_checker import kqsb_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic                     cmd_i,
  input wire logic [QID_W-1:0]         queue_id_i,
  input wire logic signed [WORD_W-1:0] data_in_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [1:0]               status_o,
  input wire logic signed [WORD_W-1:0] data_out_o
);

  // waiting input transfer holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(cmd_i) && $stable(queue_id_i)
      && $stable(data_in_i))
    else $error("waiting input changed");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(data_out_o))
    else $error("stalled result changed");

  // one item at a time: busy in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // underflow answers all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNDER |-> data_out_o == '1)
    else $error("underflow without all-ones data");

  // overflow answers zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OVER |-> data_out_o == '0)
    else $error("overflow with non-zero data");

endmodule

bind k_queues_shared_buffer kqsb_checker u_kqsb_checker (.*);

`default_nettype wire
